### rtl/core/rbp_pkg.sv
// Shared types and constants for the record burst packer.
// No dependencies.
`default_nettype none
package rbp_pkg;
  localparam int unsigned GROUPS_DEF        = 8;
  localparam int unsigned PENDING_DEPTH_DEF = 8;
  localparam int unsigned RPB_DEF           = 4;
  localparam logic [31:0] ROW_COUNT_RST     = 32'd1024;
  localparam logic [3:0]  PEND_LIMIT_RST    = 4'd4;

  typedef enum logic [1:0] {
    CMD_OFFER = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_POP   = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_STALLED  = 3'd1,
    ST_ERROR    = 3'd2,
    ST_FLUSHED  = 3'd3,
    ST_RECORD   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic {
    CFG_ROW_COUNT  = 1'b0,
    CFG_PEND_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MOVE, S_POPRD, S_POP, S_OUT
  } fsm_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  group_id;
    logic [31:0] row_index;
    logic [15:0] value_word;
    logic [31:0] record_sequence;
    logic [31:0] contributions;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_row;
    logic [15:0] out_value;
    logic [31:0] out_contributions;
    logic [1:0]  slot;
    logic [31:0] burst_number;
    logic        is_tail;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] row;
    logic [15:0] value;
    logic [31:0] contrib;
  } record_t;
endpackage
`default_nettype wire

### rtl/core/rbp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/record_burst_packer.sv
// Record burst packer top level: control FSM, per-group state, record memories.
// Depends on rbp_pkg and rbp_ram.
//
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   in_beat_t
// out       out  out_valid/out_stall out_beat_t
// cfg       in   cfg_valid/cfg_ready index, data
//
// After an input beat is taken in S_IDLE, S_READ reads the burst meta and S_EXEC
// executes; the result is then offered in S_OUT. A burst-completing offer or tail
// flush passes through S_MOVE, copying the n held records to pending memory.
// A pop delivers each record through S_POPRD, S_POP and S_OUT.
// One item in flight; output stall holds the FSM in S_OUT.
// Reset is asynchronous; record and meta memories need no clearing.
`default_nettype none
module record_burst_packer
  import rbp_pkg::*;
#(
  parameter int unsigned GROUPS        = GROUPS_DEF,
  parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int unsigned RPB           = RPB_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_beat_t  out_data_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire        cfg_index_i,
  input  wire [31:0] cfg_data_i
);
  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned RW = $clog2(RPB);
  localparam int unsigned CW = $clog2(RPB + 1);
  localparam int unsigned QW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned HD = GROUPS * RPB;
  localparam int unsigned PD = GROUPS * PENDING_DEPTH * RPB;
  localparam int unsigned MD = GROUPS * PENDING_DEPTH;
  localparam int unsigned HAW = $clog2(HD);
  localparam int unsigned PAW = $clog2(PD);
  localparam int unsigned MAW = $clog2(MD);
  localparam int unsigned RECW = $bits(record_t);
  localparam int unsigned MW = 32 + CW + 1;

  fsm_e state_q, state_d;
  in_beat_t cur_q;
  logic [31:0] row_count_q;
  logic [3:0]  limit_q;
  logic        err_q, err_d;

  logic [CW-1:0] held_cnt_q [GROUPS];
  logic [31:0]   last_seq_q [GROUPS];
  logic [31:0]   burst_num_q [GROUPS];
  logic [PW-1:0] head_q [GROUPS];
  logic [QW-1:0] qcnt_q [GROUPS];
  logic [1:0]    final_q [GROUPS];

  logic [RW:0] idx_q, idx_d;
  logic        tail_q, tail_d;
  out_beat_t   obuf_q, obuf_d;
  fsm_e        ret_q, ret_d;
  logic [CW-1:0] n_q, n_d;

  logic [GW-1:0] g;
  assign g = cur_q.group_id[GW-1:0];
  logic gbad;
  assign gbad = (GROUPS < 8) && ({29'd0, cur_q.group_id} >= 32'(GROUPS));

  logic [QW-1:0] eff_lim;
  assign eff_lim = ({28'd0, limit_q} > 32'(PENDING_DEPTH)) ?
                   QW'(PENDING_DEPTH) : QW'(limit_q);

  logic [PW:0]   tail_sum;
  logic [PW-1:0] tailpos, headpos;
  assign tail_sum = (PW+1)'(head_q[g]) + (PW+1)'(qcnt_q[g]);
  assign tailpos = (32'(tail_sum) >= PENDING_DEPTH) ?
                   PW'(32'(tail_sum) - PENDING_DEPTH) : PW'(tail_sum);
  assign headpos = head_q[g];

  // held memory
  logic            h_we;
  logic [HAW-1:0]  h_wa, h_ra;
  record_t         h_wd, h_rd;
  rbp_ram #(.WIDTH(RECW), .DEPTH(HD)) u_held (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd),
    .raddr_i(h_ra), .rdata_o(h_rd));

  logic            p_we;
  logic [PAW-1:0]  p_wa, p_ra;
  record_t         p_rd;
  rbp_ram #(.WIDTH(RECW), .DEPTH(PD)) u_pend (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(h_rd),
    .raddr_i(p_ra), .rdata_o(p_rd));

  logic [RW-1:0] idx_l;
  assign idx_l = idx_q[RW-1:0];
  logic [RW-1:0] idx_rd;

  logic          do_form, do_offer, set_fin, set_tf, do_pop;
  logic [RW-1:0] mv_prev;

  // burst meta: number, record count, tail flag
  logic [MAW-1:0] m_wa, m_ra;
  logic [MW-1:0]  m_wd, m_rd;
  logic [31:0]    m_num;
  logic [CW-1:0]  m_cnt;
  logic           m_tail;
  assign m_wa = MAW'(32'(g) * PENDING_DEPTH + 32'(tailpos));
  assign m_ra = MAW'(32'(g) * PENDING_DEPTH + 32'(headpos));
  assign m_wd = {burst_num_q[g], n_q, tail_q};
  assign {m_num, m_cnt, m_tail} = m_rd;
  rbp_ram #(.WIDTH(MW), .DEPTH(MD)) u_meta (
    .clk_i, .we_i(do_form), .waddr_i(m_wa), .wdata_i(m_wd),
    .raddr_i(m_ra), .rdata_o(m_rd));

  always_comb begin
    state_d = state_q; err_d = err_q; idx_d = idx_q; tail_d = tail_q;
    obuf_d = obuf_q; ret_d = ret_q; n_d = n_q;
    h_we = 1'b0; h_wa = HAW'(32'(g) * RPB + 32'(held_cnt_q[g]));
    h_wd = '{row: cur_q.row_index, value: cur_q.value_word,
             contrib: cur_q.contributions};
    idx_rd = idx_l;
    h_ra = HAW'(32'(g) * RPB + 32'(idx_rd));
    p_we = 1'b0; mv_prev = RW'(idx_q - 1'b1);
    p_wa = PAW'((32'(g) * PENDING_DEPTH + 32'(tailpos)) * RPB + 32'(mv_prev));
    p_ra = PAW'((32'(g) * PENDING_DEPTH + 32'(headpos)) * RPB + 32'(idx_rd));
    do_form = 1'b0; do_offer = 1'b0; set_fin = 1'b0; set_tf = 1'b0; do_pop = 1'b0;
    in_stall_o = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    cfg_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        obuf_d = '0; obuf_d.last = 1'b1; ret_d = S_IDLE; idx_d = '0;
        if (err_q || cur_q.command == CMD_BAD || gbad) begin
          obuf_d.status = ST_ERROR; err_d = 1'b1; state_d = S_OUT;
        end else begin
          unique case (cmd_e'(cur_q.command))
            CMD_OFFER: begin
              state_d = S_OUT;
              if (cur_q.row_index >= row_count_q || cur_q.record_sequence == '0 ||
                  cur_q.contributions == '0 ||
                  cur_q.record_sequence != last_seq_q[g] + 32'd1) begin
                obuf_d.status = ST_ERROR; err_d = 1'b1;
              end else if (32'(held_cnt_q[g]) >= RPB - 1 && qcnt_q[g] >= eff_lim) begin
                obuf_d.status = ST_STALLED;
              end else begin
                obuf_d.status = ST_ACCEPTED; do_offer = 1'b1; h_we = 1'b1;
                if (32'(held_cnt_q[g]) == RPB - 1) begin
                  state_d = S_MOVE; tail_d = 1'b0; n_d = CW'(RPB); ret_d = S_IDLE;
                end
              end
            end
            CMD_FLUSH: begin
              obuf_d.status = ST_FLUSHED; set_fin = 1'b1; state_d = S_OUT;
              if (!final_q[g][1]) begin
                if (held_cnt_q[g] != '0 && qcnt_q[g] < eff_lim) begin
                  obuf_d.is_tail = 1'b1; tail_d = 1'b1; n_d = held_cnt_q[g];
                  state_d = S_MOVE; ret_d = S_IDLE; set_tf = 1'b1;
                end else if (held_cnt_q[g] == '0) set_tf = 1'b1;
              end
            end
            CMD_POP: begin
              if (qcnt_q[g] == '0 || m_cnt == '0) begin
                obuf_d.status = ST_EMPTY; state_d = S_OUT;
                if (qcnt_q[g] != '0) do_pop = 1'b1;
              end else begin
                n_d = m_cnt;
                state_d = S_POPRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOVE: begin
        // read idx, write idx-1 from previous read
        if (idx_q != '0) p_we = 1'b1;
        if (idx_q == (RW+1)'(n_q)) begin
          do_form = 1'b1; state_d = S_OUT; idx_d = '0;
        end else idx_d = idx_q + 1'b1;
      end
      S_POPRD: begin
        state_d = S_POP;
      end
      S_POP: begin
        obuf_d = '0;
        obuf_d.status = ST_RECORD; obuf_d.out_row = p_rd.row;
        obuf_d.out_value = p_rd.value; obuf_d.out_contributions = p_rd.contrib;
        obuf_d.slot = 2'(idx_q);
        obuf_d.burst_number = m_num;
        obuf_d.is_tail = m_tail;
        obuf_d.last = (idx_q + 1'b1 == (RW+1)'(n_q));
        ret_d = obuf_d.last ? S_IDLE : S_POPRD;
        if (obuf_d.last) do_pop = 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = ret_q;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_POPRD || state_q == S_OUT) idx_rd = idx_l;
  end

  assign out_data_o = obuf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; err_q <= 1'b0; row_count_q <= ROW_COUNT_RST;
      limit_q <= PEND_LIMIT_RST; idx_q <= '0; ret_q <= S_IDLE;
      for (int i = 0; i < GROUPS; i++) begin
        held_cnt_q[i] <= '0; last_seq_q[i] <= '0; burst_num_q[i] <= 32'd1;
        head_q[i] <= '0; qcnt_q[i] <= '0; final_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; err_q <= err_d; idx_q <= idx_d; ret_q <= ret_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ROW_COUNT) row_count_q <= cfg_data_i;
        else limit_q <= cfg_data_i[3:0];
      end
      if (do_offer) begin
        held_cnt_q[g] <= held_cnt_q[g] + 1'b1;
        last_seq_q[g] <= cur_q.record_sequence;
      end
      if (set_fin) final_q[g][0] <= 1'b1;
      if (set_tf) final_q[g][1] <= 1'b1;
      if (do_form) begin
        burst_num_q[g] <= burst_num_q[g] + 32'd1;
        qcnt_q[g] <= qcnt_q[g] + 1'b1;
        held_cnt_q[g] <= '0;
      end
      if (do_pop) begin
        head_q[g] <= (32'(headpos) + 1 >= PENDING_DEPTH) ? '0 : PW'(32'(headpos) + 1);
        qcnt_q[g] <= qcnt_q[g] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) cur_q <= in_data_i;
    obuf_q <= obuf_d; tail_q <= tail_d; n_q <= n_d;
  end

`ifndef NO_ASSERTIONS
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q) else $error("error flag cleared");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while output pending");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !out_valid_o) else $error("cfg ready while busy");
`endif
endmodule
`default_nettype wire
